// ===== hdl/agal_pkg.sv =====
// Shared types and constants for the address-space tag allocator.
package agal_pkg;

  // Operation codes carried by a command transaction.
  typedef enum logic [1:0] {
    OP_SWITCH   = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_ROLLOVER = 2'd2,
    OP_REINIT   = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARANOID = 1'b1;

  // Smallest nonzero tag width accepted by reinit.
  localparam logic [4:0] MIN_TAG_BITS = 5'd8;

  // Bitmap word geometry: 64 tags per word.
  localparam int WORD_BITS = 64;
  localparam int BIT_IDX_W = 6;
  localparam int GRP_BITS  = 8;
  localparam int GRP_CNT   = WORD_BITS / GRP_BITS;
  localparam int GRP_IDX_W = 3;

  // Every CPU index code that the command can carry.
  localparam int CPU_SLOTS = 64;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  cpu_index;
    logic        has_context;
    logic [15:0] context_tag;
    logic [63:0] context_generation;
  } cmd_t;

  typedef struct packed {
    logic [15:0] tag_out;
    logic [63:0] generation_out;
    logic        flush_needed;
    logic        accepted;
    logic [31:0] alloc_count;
    logic [31:0] rollover_count;
    logic [31:0] flush_count;
    logic [31:0] release_count;
  } result_t;

  // Outcome of one free-bit search over a bitmap word.
  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] bit_idx;
  } find_res_t;

endpackage

// ===== hdl/agal_find_free.sv =====
// Two-step search for the lowest set bit of a 64-bit free mask.
module agal_find_free (
  input  logic                                clk,
  input  logic [agal_pkg::WORD_BITS-1:0]      free_mask,
  output agal_pkg::find_res_t                 res
);

  logic [agal_pkg::WORD_BITS-1:0] mask_q;
  logic [agal_pkg::GRP_CNT-1:0]   grp_nz_q;

  // Register the mask and one nonzero flag per 8-bit group.
  always_ff @(posedge clk) begin
    mask_q <= free_mask;
    for (int g = 0; g < agal_pkg::GRP_CNT; g++) begin
      grp_nz_q[g] <= |free_mask[g*agal_pkg::GRP_BITS +: agal_pkg::GRP_BITS];
    end
  end

  // Pick the lowest nonzero group, then the lowest set bit inside it.
  always_comb begin
    logic [agal_pkg::GRP_IDX_W-1:0] grp_sel;
    logic [agal_pkg::GRP_IDX_W-1:0] bit_sel;
    logic [agal_pkg::GRP_BITS-1:0]  grp_bits;
    grp_sel = '0;
    bit_sel = '0;
    for (int g = agal_pkg::GRP_CNT - 1; g >= 0; g--) begin
      if (grp_nz_q[g]) begin
        grp_sel = agal_pkg::GRP_IDX_W'(g);
      end
    end
    grp_bits = mask_q[grp_sel*agal_pkg::GRP_BITS +: agal_pkg::GRP_BITS];
    for (int b = agal_pkg::GRP_BITS - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = agal_pkg::GRP_IDX_W'(b);
      end
    end
    res.found   = |grp_nz_q;
    res.bit_idx = {grp_sel, bit_sel};
  end

endmodule

// ===== hdl/asid_generation_allocator_core.sv =====
// Top level of the address-space tag allocator with generation rollover.
// Switch: decode, then read, mask and pick for each bitmap word scanned on the one read port,
//   then stamp and done.
// A rollover (forced, reinit or bitmap full) clears 2^(tag_bits-6) words, one per clear step.
// Release: decode, then read and write its word. One transaction at a time: busy stays high.
// Reset (rst, synchronous): control, counters and stamp valid bits clear at once; no sweep.
module asid_generation_allocator_core #(
  parameter int MAX_TAG_BITS = 16,
  parameter int NUM_CPUS     = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  agal_pkg::cmd_t                       cmd,
  output logic                                 busy,
  output logic                                 done,
  output agal_pkg::result_t                    result,
  input  logic                                 cfg_we,
  input  logic [agal_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [agal_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int WORD_W    = MAX_TAG_BITS - agal_pkg::BIT_IDX_W;
  localparam int MAP_WORDS = 1 << WORD_W;
  localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam logic [WORD_W-1:0] WORD_ONES = '1;
  localparam logic [4:0]        MAX_BITS5 = 5'(MAX_TAG_BITS);
  localparam logic [agal_pkg::WORD_BITS-1:0] ALL_ONES = '1;

  // Sequencer: each state is one step of the shared scan/clear datapath.
  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DECODE    = 10'b00_0000_0010,
    S_SCAN_RD   = 10'b00_0000_0100,
    S_SCAN_WAIT = 10'b00_0000_1000,
    S_SCAN_EVAL = 10'b00_0001_0000,
    S_CLEAR     = 10'b00_0010_0000,
    S_REL_RD    = 10'b00_0100_0000,
    S_REL_WR    = 10'b00_1000_0000,
    S_STAMP     = 10'b01_0000_0000,
    S_DONE      = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Configuration and allocator state.
  logic [4:0]              tag_bits;
  logic                    paranoid;
  logic [4:0]              active_bits;
  logic [MAX_TAG_BITS-1:0] scan_cursor;
  logic [63:0]             cur_gen;
  logic [31:0]             alloc_cnt;
  logic [31:0]             roll_cnt;
  logic [31:0]             flush_cnt;
  logic [31:0]             rel_cnt;
  logic [NUM_CPUS-1:0]     stamp_valid;

  // Latched transaction and working registers.
  agal_pkg::op_t           op_r;
  logic [CPU_W-1:0]        cpu_r;
  logic                    has_ctx_r;
  logic [15:0]             ctag_r;
  logic [63:0]             cgen_r;
  logic                    flush_r;
  logic                    ok_r;
  logic [WORD_W-1:0]       scan_w;
  logic                    phase_b;
  logic                    resume_scan;
  logic [agal_pkg::BIT_IDX_W-1:0] rel_bit;

  // Bitmap memory: one port, written or read each cycle, registered read data.
  logic [agal_pkg::WORD_BITS-1:0] bitmap [MAP_WORDS];
  logic                           bm_re;
  logic                           bm_we;
  logic [agal_pkg::WORD_BITS-1:0] bm_wdata;
  logic [agal_pkg::WORD_BITS-1:0] bm_rd;

  // Per-CPU flush stamps: memory plus valid bits that reset and reinit clear.
  logic [63:0]             stamp_mem [NUM_CPUS];
  logic [63:0]             stamp_rd;
  logic [63:0]             stamp_cur;
  logic                    stamp_diff;

  // CPU index reduction table, worked out at elaboration.
  logic [CPU_W-1:0]        cpu_map [agal_pkg::CPU_SLOTS];

  for (genvar gi = 0; gi < agal_pkg::CPU_SLOTS; gi++) begin : g_cpu_map
    localparam int unsigned Rem = gi % NUM_CPUS;
    assign cpu_map[gi] = CPU_W'(Rem);
  end

  // Scan geometry.
  logic [WORD_W-1:0]              last_word;
  logic [WORD_W-1:0]              cur_word;
  logic [agal_pkg::BIT_IDX_W-1:0] cur_bit;
  logic [agal_pkg::WORD_BITS-1:0] hi_mask;
  logic [agal_pkg::WORD_BITS-1:0] valid_mask;
  logic [agal_pkg::WORD_BITS-1:0] free_mask;
  agal_pkg::find_res_t            find_res;
  logic [MAX_TAG_BITS-1:0]        claim_tag;
  logic [agal_pkg::BIT_IDX_W-1:0] sel_bit;
  logic [agal_pkg::WORD_BITS-1:0] bit_onehot;
  logic                           tag_bits_ok;
  logic                           rel_in_range;

  // Last bitmap word of the active tag space (tag count is a multiple of 64).
  assign last_word = WORD_ONES >> (MAX_BITS5 - active_bits);
  assign cur_word  = scan_cursor[MAX_TAG_BITS-1:agal_pkg::BIT_IDX_W];
  assign cur_bit   = scan_cursor[agal_pkg::BIT_IDX_W-1:0];
  assign hi_mask   = ALL_ONES << cur_bit;

  // First pass covers tags at or above the cursor; the wrapped pass covers tags
  // below it. Tag 0 is never handed out.
  always_comb begin
    if (scan_w == cur_word) begin
      valid_mask = phase_b ? ~hi_mask : hi_mask;
    end else begin
      valid_mask = ALL_ONES;
    end
    if (scan_w == '0) begin
      valid_mask[0] = 1'b0;
    end
  end

  assign free_mask = ~bm_rd & valid_mask;

  agal_find_free u_find (
    .clk       (clk),
    .free_mask (free_mask),
    .res       (find_res)
  );

  // The context tag is already cleared when the release write happens, so the
  // released bit position is held in rel_bit.
  assign claim_tag  = {scan_w, find_res.bit_idx};
  assign sel_bit    = (state == S_SCAN_EVAL) ? find_res.bit_idx : rel_bit;
  assign bit_onehot = {{(agal_pkg::WORD_BITS-1){1'b0}}, 1'b1} << sel_bit;

  assign tag_bits_ok  = (tag_bits == 5'd0) ||
                        ((tag_bits >= agal_pkg::MIN_TAG_BITS) && (tag_bits <= MAX_BITS5));
  assign rel_in_range = (ctag_r >> MAX_TAG_BITS) == 16'd0;

  assign stamp_cur  = stamp_valid[cpu_r] ? stamp_rd : 64'd0;
  assign stamp_diff = stamp_cur != cur_gen;

  // Bitmap port control: scan reads, claim and release read-modify-writes, clear sweep.
  always_comb begin
    bm_re    = 1'b0;
    bm_we    = 1'b0;
    bm_wdata = bm_rd;
    unique case (state)
      S_SCAN_RD, S_REL_RD: begin
        bm_re = 1'b1;
      end
      S_SCAN_EVAL: begin
        bm_we    = find_res.found;
        bm_wdata = bm_rd | bit_onehot;
      end
      S_REL_WR: begin
        bm_we    = 1'b1;
        bm_wdata = bm_rd & ~bit_onehot;
      end
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_wdata = '0;
      end
      default: begin
        bm_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap[scan_w] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rd <= bitmap[scan_w];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      stamp_rd <= stamp_mem[cpu_r];
    end
    if (state == S_STAMP && stamp_diff) begin
      stamp_mem[cpu_r] <= cur_gen;
    end
  end

  // Sequencer and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tag_bits    <= 5'd0;
      paranoid    <= 1'b0;
      active_bits <= 5'd0;
      scan_cursor <= MAX_TAG_BITS'(1);
      cur_gen     <= 64'd0;
      alloc_cnt   <= 32'd0;
      roll_cnt    <= 32'd0;
      flush_cnt   <= 32'd0;
      rel_cnt     <= 32'd0;
      stamp_valid <= '0;
      resume_scan <= 1'b0;
      phase_b     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          agal_pkg::CFG_TAG_BITS: tag_bits <= cfg_data;
          agal_pkg::CFG_PARANOID: paranoid <= cfg_data[0];
          default:                tag_bits <= tag_bits;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r      <= agal_pkg::op_t'(cmd.operation);
            cpu_r     <= cpu_map[cmd.cpu_index];
            has_ctx_r <= cmd.has_context;
            ctag_r    <= cmd.has_context ? cmd.context_tag : 16'd0;
            cgen_r    <= cmd.has_context ? cmd.context_generation : 64'd0;
            flush_r   <= 1'b0;
            ok_r      <= 1'b0;
            state     <= S_DECODE;
          end
        end

        S_DECODE: begin
          state <= S_DONE;
          unique case (op_r)
            agal_pkg::OP_SWITCH: begin
              ok_r <= 1'b1;
              if (active_bits == 5'd0) begin
                flush_r <= 1'b1;
              end else if (has_ctx_r && (cgen_r != cur_gen)) begin
                scan_w  <= cur_word;
                phase_b <= 1'b0;
                state   <= S_SCAN_RD;
              end else begin
                state <= S_STAMP;
              end
            end
            agal_pkg::OP_RELEASE: begin
              if (active_bits != 5'd0 && has_ctx_r && ctag_r != 16'd0) begin
                if (cgen_r == cur_gen) begin
                  rel_cnt <= rel_cnt + 32'd1;
                  ok_r    <= 1'b1;
                  if (rel_in_range) begin
                    scan_w  <= ctag_r[MAX_TAG_BITS-1:agal_pkg::BIT_IDX_W];
                    rel_bit <= ctag_r[agal_pkg::BIT_IDX_W-1:0];
                    state   <= S_REL_RD;
                  end
                end
                ctag_r <= 16'd0;
                cgen_r <= 64'd0;
              end
            end
            agal_pkg::OP_ROLLOVER: begin
              if (active_bits != 5'd0) begin
                cur_gen     <= cur_gen + 64'd1;
                roll_cnt    <= roll_cnt + 32'd1;
                scan_cursor <= MAX_TAG_BITS'(1);
                scan_w      <= '0;
                resume_scan <= 1'b0;
                ok_r        <= 1'b1;
                state       <= S_CLEAR;
              end
            end
            agal_pkg::OP_REINIT: begin
              if (tag_bits_ok) begin
                active_bits <= tag_bits;
                scan_cursor <= MAX_TAG_BITS'(1);
                cur_gen     <= cur_gen + 64'd1;
                alloc_cnt   <= 32'd0;
                roll_cnt    <= 32'd0;
                flush_cnt   <= 32'd0;
                rel_cnt     <= 32'd0;
                stamp_valid <= '0;
                scan_w      <= '0;
                resume_scan <= 1'b0;
                ok_r        <= 1'b1;
                // Clear only the words the new tag space reaches.
                if (tag_bits != 5'd0) begin
                  state <= S_CLEAR;
                end
              end
            end
            default: state <= S_DONE;
          endcase
        end

        S_SCAN_RD: begin
          state <= S_SCAN_WAIT;
        end

        S_SCAN_WAIT: begin
          state <= S_SCAN_EVAL;
        end

        S_SCAN_EVAL: begin
          if (find_res.found) begin
            alloc_cnt <= alloc_cnt + 32'd1;
            ctag_r    <= 16'(claim_tag);
            cgen_r    <= cur_gen;
            if (scan_w == last_word && find_res.bit_idx == '1) begin
              scan_cursor <= MAX_TAG_BITS'(1);
            end else begin
              scan_cursor <= claim_tag + MAX_TAG_BITS'(1);
            end
            state <= S_STAMP;
          end else if (!phase_b) begin
            // Wrap past tag 0 after the last word.
            if (scan_w == last_word) begin
              phase_b <= 1'b1;
              scan_w  <= '0;
            end else begin
              scan_w <= scan_w + WORD_W'(1);
            end
            state <= S_SCAN_RD;
          end else if (scan_w == cur_word) begin
            // Bitmap full: advance the generation, clear, then rescan.
            cur_gen     <= cur_gen + 64'd1;
            roll_cnt    <= roll_cnt + 32'd1;
            scan_cursor <= MAX_TAG_BITS'(1);
            scan_w      <= '0;
            resume_scan <= 1'b1;
            state       <= S_CLEAR;
          end else begin
            scan_w <= scan_w + WORD_W'(1);
            state  <= S_SCAN_RD;
          end
        end

        S_CLEAR: begin
          if (scan_w == last_word) begin
            if (resume_scan) begin
              resume_scan <= 1'b0;
              phase_b     <= 1'b0;
              scan_w      <= '0;
              state       <= S_SCAN_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            scan_w <= scan_w + WORD_W'(1);
          end
        end

        S_REL_RD: begin
          state <= S_REL_WR;
        end

        S_REL_WR: begin
          state <= S_DONE;
        end

        S_STAMP: begin
          if (stamp_diff) begin
            stamp_valid[cpu_r] <= 1'b1;
            flush_cnt          <= flush_cnt + 32'd1;
            flush_r            <= 1'b1;
          end
          if (paranoid) begin
            flush_r <= 1'b1;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  assign result.tag_out        = ctag_r;
  assign result.generation_out = cgen_r;
  assign result.flush_needed   = flush_r;
  assign result.accepted       = ok_r;
  assign result.alloc_count    = alloc_cnt;
  assign result.rollover_count = roll_cnt;
  assign result.flush_count    = flush_cnt;
  assign result.release_count  = rel_cnt;

`ifndef SYNTHESIS
  // The result strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // A transaction ends only through its result.
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> $past(done))
    else $error("busy dropped without a result");

  // The scan never reads past the active tag space.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_RD) |-> (scan_w <= last_word))
    else $error("scan word beyond active tag space");

  // Tag 0 is never the scan start.
  a_cursor_nz: assert property (@(posedge clk) disable iff (rst)
    (active_bits != 5'd0) |-> (scan_cursor != '0))
    else $error("scan cursor at tag 0");
`endif

endmodule

// ===== tb/asid_alloc_scoreboard.sv =====
// Scoreboard for the tag allocator: mirrors allocation state and checks every result.
`timescale 1ns / 1ps

module asid_alloc_scoreboard
  import agal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  cmd_t                  cmd,
  input  logic                  done,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  final_check,
  output int                    fail_count
);

  localparam int TAG_WIDTH_MAX = 16;
  localparam int MAP_DEPTH     = 1024;
  localparam int PRINT_CAP     = 50;

  // Mirror of the allocator.
  bit   [63:0] map_w [0:MAP_DEPTH-1];
  int unsigned cursor;
  logic [63:0] gen_now;
  logic [63:0] cpu_stamp [0:CPU_SLOTS-1];
  logic [4:0]  width_now;
  logic [31:0] n_alloc, n_roll, n_flush, n_rel;
  logic [4:0]  reg_tag_bits;
  logic        reg_paranoid;

  result_t outcomes_due [$];
  int      fails = 0;
  int      n_checked = 0;

  assign fail_count = fails;

  task automatic report_mismatch(input string what);
    if (fails < PRINT_CAP) $display("[scoreboard] %0t ns: %s", $time, what);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("transaction %0d %s got %0h want %0h",
                                n_checked, name, got, want));
  endtask

  function automatic void wipe_map();
    int i;
    for (i = 0; i < MAP_DEPTH; i++) map_w[i] = '0;
  endfunction

  function automatic void reset_model();
    int i;
    wipe_map();
    for (i = 0; i < CPU_SLOTS; i++) cpu_stamp[i] = '0;
    cursor       = 1;
    gen_now      = '0;
    width_now    = '0;
    n_alloc      = '0;
    n_roll       = '0;
    n_flush      = '0;
    n_rel        = '0;
    reg_tag_bits = '0;
    reg_paranoid = 1'b0;
  endfunction

  function automatic bit claim_tag(input int unsigned t);
    int unsigned w;
    w = (t >> 6) & (MAP_DEPTH - 1);
    if (map_w[w][t & 63]) return 1'b0;
    map_w[w][t & 63] = 1'b1;
    return 1'b1;
  endfunction

  // Round-robin search from the cursor, wrapping past tag 0; 0 means full.
  function automatic int unsigned find_free_tag();
    int unsigned span, t, i;
    span = 32'd1 << width_now;
    for (i = 0; i + 1 < span; i++) begin
      t = cursor + i;
      if (t >= span) t -= span - 1;
      if (claim_tag(t)) begin
        cursor = (t + 1 >= span) ? 1 : t + 1;
        return t;
      end
    end
    return 0;
  endfunction

  function automatic void roll_over();
    gen_now++;
    wipe_map();
    cursor = 1;
    n_roll++;
  endfunction

  // Advance the mirror by one command and return the result it must produce.
  function automatic result_t apply_command(input cmd_t c);
    result_t     r;
    logic [15:0] ctag;
    logic [63:0] cgen, gnow;
    int unsigned t, i;
    bit          fl, ok;
    fl   = 1'b0;
    ok   = 1'b0;
    ctag = c.has_context ? c.context_tag : 16'd0;
    cgen = c.has_context ? c.context_generation : 64'd0;
    case (op_t'(c.operation))
      OP_SWITCH: begin
        ok = 1'b1;
        if (width_now == 0) begin
          fl = 1'b1;
        end else begin
          gnow = gen_now;
          if (c.has_context && cgen != gnow) begin
            t = find_free_tag();
            if (t == 0) begin
              roll_over();
              t = find_free_tag();
            end
            gnow = gen_now;
            n_alloc++;
            ctag = 16'(t);
            cgen = gnow;
          end
          if (cpu_stamp[c.cpu_index] != gnow) begin
            cpu_stamp[c.cpu_index] = gnow;
            n_flush++;
            fl = 1'b1;
          end
          if (reg_paranoid) fl = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (width_now != 0 && c.has_context && ctag != 0) begin
          if (cgen == gen_now) begin
            map_w[ctag[15:6]][ctag[5:0]] = 1'b0;
            n_rel++;
            ok = 1'b1;
          end
          ctag = '0;
          cgen = '0;
        end
      end
      OP_ROLLOVER: begin
        if (width_now != 0) begin
          roll_over();
          ok = 1'b1;
        end
      end
      default: begin
        if (reg_tag_bits == 0 ||
            (reg_tag_bits >= MIN_TAG_BITS && reg_tag_bits <= TAG_WIDTH_MAX)) begin
          width_now = reg_tag_bits;
          cursor    = 1;
          gen_now++;
          wipe_map();
          n_alloc = '0;
          n_roll  = '0;
          n_flush = '0;
          n_rel   = '0;
          for (i = 0; i < CPU_SLOTS; i++) cpu_stamp[i] = '0;
          ok = 1'b1;
        end
      end
    endcase
    r.tag_out        = ctag;
    r.generation_out = cgen;
    r.flush_needed   = fl;
    r.accepted       = ok;
    r.alloc_count    = n_alloc;
    r.rollover_count = n_roll;
    r.flush_count    = n_flush;
    r.release_count  = n_rel;
    return r;
  endfunction

  initial reset_model();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      reset_model();
      outcomes_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TAG_BITS) reg_tag_bits = cfg_data;
        else                           reg_paranoid = cfg_data[0];
      end
      // Retire the oldest outcome before queuing one for a new command.
      if (done) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result strobe with no command outstanding");
        end else begin
          want = outcomes_due.pop_front();
          check_field("tag_out",        result.tag_out,        want.tag_out);
          check_field("generation_out", result.generation_out, want.generation_out);
          check_field("flush_needed",   result.flush_needed,   want.flush_needed);
          check_field("accepted",       result.accepted,       want.accepted);
          check_field("alloc_count",    result.alloc_count,    want.alloc_count);
          check_field("rollover_count", result.rollover_count, want.rollover_count);
          check_field("flush_count",    result.flush_count,    want.flush_count);
          check_field("release_count",  result.release_count,  want.release_count);
        end
        n_checked++;
      end
      if (start && !busy) outcomes_due.push_back(apply_command(cmd));
      if (final_check && outcomes_due.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the tag allocator testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import agal_pkg::*;

  // Context carried by an address space: the tag and the generation it was tagged in.
  typedef struct packed {
    logic [15:0] tag;
    logic [63:0] gen;
  } ctx_t;

  localparam int POOL_MAX = 48;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  cmd_t                  cmd = '0;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TAG_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  final_check = 1'b0;
  int                    sb_fails;

  // Sender-side bookkeeping: transactions issued and returned, the operation of
  // each one in flight, and a pool of live contexts handed out by switches.
  int      n_sent = 0;
  int      n_returned = 0;
  op_t     ops_in_flight [$];
  ctx_t    live_ctx [$];
  result_t last_result = '0;

  asid_generation_allocator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  asid_alloc_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .final_check (final_check),
    .fail_count  (sb_fails)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch returning results; harvest the contexts that switches hand out so
  // later releases and repeat switches use real, often current, contexts.
  always @(posedge clk) begin
    op_t op;
    if (!rst && done) begin
      n_returned++;
      last_result = result;
      if (ops_in_flight.size() != 0) begin
        op = ops_in_flight.pop_front();
        if (op == OP_SWITCH && result.tag_out != 0) begin
          if (live_ctx.size() >= POOL_MAX) void'(live_ctx.pop_front());
          live_ctx.push_back({result.tag_out, result.generation_out});
        end
      end
    end
  end

  function automatic cmd_t pack_command(input op_t op, input logic [5:0] cpu,
                                        input logic hc, input logic [15:0] tag,
                                        input logic [63:0] gen);
    cmd_t c;
    c.operation          = op;
    c.cpu_index          = cpu;
    c.has_context        = hc;
    c.context_tag        = tag;
    c.context_generation = gen;
    return c;
  endfunction

  // Present one command and hold it until the block takes it. Leave start high:
  // the caller drops it when a gap or a drain follows.
  task automatic send_cmd(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    ops_in_flight.push_back(op_t'(c.operation));
    n_sent++;
  endtask

  // Drop start and wait until every transaction in flight has returned.
  task automatic drain_results();
    start <= 1'b0;
    while (n_returned != n_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One register write; hold the enable for one cycle, then wait with it low.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic configure(input logic [4:0] width, input logic strict);
    drain_results();
    write_reg(CFG_TAG_BITS, width);
    write_reg(CFG_PARANOID, {{(CFG_DATA_W-1){1'b0}}, strict});
  endtask

  // Mostly well-formed traffic: switches of stale and live contexts, releases of
  // live contexts, with some rollovers, reinits and raw noise mixed in. In fill
  // mode nearly everything is a stale switch, to drive the bitmap to full.
  function automatic cmd_t random_command(input bit fill_mode);
    cmd_t        c;
    ctx_t        x;
    int unsigned pick;
    int          k;
    c.operation          = OP_SWITCH;
    c.cpu_index          = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 3))
                                                       : 6'($urandom_range(0, 63));
    c.has_context        = 1'b1;
    c.context_tag        = 16'($urandom);
    c.context_generation = {$urandom, $urandom};
    if (fill_mode && $urandom_range(0, 99) < 85) pick = 0;
    else                                         pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // Stale context; generation 0 is always behind after a reinit.
      if ($urandom_range(0, 7) == 0) c.context_generation = '0;
    end else if (pick < 60) begin
      if (live_ctx.size() != 0) begin
        k = ($urandom_range(0, 1) == 0) ? live_ctx.size() - 1
                                        : $urandom_range(0, live_ctx.size() - 1);
        x = live_ctx[k];
        c.context_tag        = x.tag;
        c.context_generation = x.gen;
      end
    end else if (pick < 65) begin
      c.has_context = 1'b0;
    end else if (pick < 85) begin
      c.operation = OP_RELEASE;
      if (live_ctx.size() != 0) begin
        k = $urandom_range(0, live_ctx.size() - 1);
        x = live_ctx[k];
        live_ctx.delete(k);
        c.context_tag        = x.tag;
        c.context_generation = x.gen;
      end
    end else if (pick < 90) begin
      c.operation = OP_RELEASE;
      if (live_ctx.size() != 0 && $urandom_range(0, 1) == 0)
        c.context_generation = live_ctx[live_ctx.size() - 1].gen;
    end else if (pick < 94) begin
      c.operation = OP_ROLLOVER;
    end else if (pick < 96) begin
      c.operation = OP_REINIT;
    end else begin
      c.operation   = op_t'($urandom_range(0, 3));
      c.has_context = 1'($urandom_range(0, 1));
    end
    return c;
  endfunction

  // Reprogram, reinit, then stream random commands in bursts with random gaps.
  task automatic run_phase(input logic [4:0] width, input logic strict,
                           input int count, input bit fill_mode);
    int left, burst, gap_kind;
    configure(width, strict);
    send_cmd(pack_command(OP_REINIT, 6'($urandom_range(0, 63)), 1'b1,
                          16'($urandom), {$urandom, $urandom}));
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_cmd(random_command(fill_mode));
        burst--;
        left--;
      end
      gap_kind = $urandom_range(0, 19);
      if (gap_kind == 0) begin
        // Hold off until the block has returned everything.
        drain_results();
      end else if (gap_kind >= 8) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      // Otherwise keep start high: the next burst follows back to back.
    end
  endtask

  initial begin
    ctx_t held;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No tags configured: switch flushes, release and rollover are refused.
    send_cmd(pack_command(OP_SWITCH, 6'd0, 1'b1, 16'd5, 64'd7));
    send_cmd(pack_command(OP_RELEASE, 6'd1, 1'b1, 16'd5, 64'd0));
    send_cmd(pack_command(OP_ROLLOVER, 6'd2, 1'b0, 16'd0, 64'd0));

    // Reinit refuses widths below the minimum and above the maximum.
    configure(5'd7, 1'b0);
    send_cmd(pack_command(OP_REINIT, 6'd0, 1'b0, 16'd0, 64'd0));
    configure(5'd31, 1'b0);
    send_cmd(pack_command(OP_REINIT, 6'd0, 1'b1, 16'hFFFF, '1));

    // Zero width is legal and leaves every switch flushing.
    configure(5'd0, 1'b0);
    send_cmd(pack_command(OP_REINIT, 6'd0, 1'b0, 16'd0, 64'd0));
    send_cmd(pack_command(OP_SWITCH, 6'd3, 1'b1, 16'd9, 64'd1));

    // Narrowest real width: allocate, then reuse the context while current.
    configure(5'd8, 1'b0);
    send_cmd(pack_command(OP_REINIT, 6'd0, 1'b0, 16'd0, 64'd0));
    send_cmd(pack_command(OP_SWITCH, 6'd0, 1'b1, 16'd0, 64'd0));
    drain_results();
    held = {last_result.tag_out, last_result.generation_out};
    send_cmd(pack_command(OP_SWITCH, 6'd0, 1'b1, held.tag, held.gen));
    // No context: outputs carry zeros whatever the fields hold.
    send_cmd(pack_command(OP_SWITCH, 6'd63, 1'b0, 16'hFFFF, '1));

    // Release: current, repeated, tag 0, no context, stale, beyond the range.
    send_cmd(pack_command(OP_RELEASE, 6'd5, 1'b1, held.tag, held.gen));
    send_cmd(pack_command(OP_RELEASE, 6'd5, 1'b1, held.tag, held.gen));
    send_cmd(pack_command(OP_RELEASE, 6'd5, 1'b1, 16'd0, held.gen));
    send_cmd(pack_command(OP_RELEASE, 6'd5, 1'b0, held.tag, held.gen));
    send_cmd(pack_command(OP_RELEASE, 6'd5, 1'b1, 16'd3, held.gen - 64'd1));
    send_cmd(pack_command(OP_RELEASE, 6'd5, 1'b1, 16'hFFFF, held.gen));
    send_cmd(pack_command(OP_ROLLOVER, 6'd0, 1'b1, held.tag, held.gen));

    // Paranoid mode flushes even when the context and the stamp are current.
    configure(5'd8, 1'b1);
    send_cmd(pack_command(OP_SWITCH, 6'd7, 1'b1, held.tag, held.gen));
    drain_results();
    held = {last_result.tag_out, last_result.generation_out};
    send_cmd(pack_command(OP_SWITCH, 6'd7, 1'b1, held.tag, held.gen));

    // Widest width with all-ones fields, then a full-width rollover.
    configure(5'd16, 1'b0);
    send_cmd(pack_command(OP_REINIT, 6'd0, 1'b0, 16'd0, 64'd0));
    send_cmd(pack_command(OP_SWITCH, 6'd63, 1'b1, 16'hFFFF, '1));
    send_cmd(pack_command(OP_ROLLOVER, 6'd63, 1'b1, 16'hFFFF, '1));

    // Random phases; the fill phases run the narrow bitmap out of tags.
    run_phase(5'd8,  1'b0, 350, 1'b1);
    run_phase(5'd9,  1'b1, 150, 1'b0);
    run_phase(5'd16, 1'b0, 150, 1'b0);
    run_phase(5'd0,  1'b0, 60,  1'b0);
    run_phase(5'd3,  1'b0, 20,  1'b0);
    run_phase(5'd12, 1'b1, 150, 1'b0);
    run_phase(5'd8,  1'b0, 150, 1'b1);
    run_phase(5'd31, 1'b1, 70,  1'b0);

    // Let the last transaction finish, then flag anything still outstanding.
    drain_results();
    repeat (20) @(posedge clk);
    final_check <= 1'b1;
    @(posedge clk);
    final_check <= 1'b0;
    repeat (2) @(posedge clk);

    if (sb_fails == 0) begin
      $display("[asid_generation_allocator_core] OK");
    end else begin
      $display("[asid_generation_allocator_core] ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("[asid_generation_allocator_core] ERROR");
    $finish;
  end

endmodule
